// ----- rtl/cfej_pkg.sv -----
// Shared types, constants and fixed-point helpers for the element Jacobian core.
// No dependencies; used by every module in rtl/.
package cfej_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned TDATA_IN_W    = 320;
  localparam int unsigned TDATA_OUT_W   = 136;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] wide_t;

  typedef enum logic [0:0] {
    REG_COUPLING_GAIN = 1'b0,
    REG_GHOST_SCALE   = 1'b1
  } reg_idx_t;

  // Basis value by count of small 1-D factors, Q1.31
  localparam word_t BASIS_Q31 [3] = '{32'sd1335753014, 32'sd357913941, 32'sd95902752};
  // Basis product N_a*N_b by count of small factors, Q1.31
  localparam word_t PAIR_Q31 [5] = '{32'sd830849686, 32'sd222625502, 32'sd59652324,
                                     32'sd15983792, 32'sd4282844};

  // small factors in N_node at Gauss point (i, j)
  function automatic logic [1:0] small_count(input logic [1:0] node, input logic i,
                                             input logic j);
    logic xhi;
    logic thi;
    xhi = (node == 2'd1) || (node == 2'd2);
    thi = node[1];
    return {1'b0, xhi != i} + {1'b0, thi != j};
  endfunction

  function automatic word_t sat32(input wide_t v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round half up, then arithmetic shift (floor)
  function automatic wide_t rnd_shr(input wide_t v, input int unsigned s);
    wide_t x;
    x = v + (64'sd1 <<< (s - 1));
    return x >>> s;
  endfunction

  function automatic word_t qmul(input word_t a, input word_t b, input int unsigned s);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return sat32(rnd_shr(p, s));
  endfunction

endpackage

// ----- rtl/cfej_front.sv -----
// Gauss-point pipeline: interpolation, coupling derivatives, detJ and ghost scaling.
// Six register stages, one lane per Gauss point. Depends on cfej_pkg.
module cfej_front #(
  parameter int unsigned FRAC_BITS = cfej_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cfej_pkg::word_t     phi [4],
  input  cfej_pkg::word_t     chi [4],
  input  logic [31:0]         hx,
  input  logic [31:0]         ht,
  input  cfej_pkg::word_t     lam,
  input  cfej_pkg::word_t     ghost,
  output logic                out_valid,
  input  logic                out_ready,
  output cfej_pkg::word_t     c_out [4][4]
);
  import cfej_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rd1, rd2, rd3, rd4, rd5, rd6;

  assign rd6 = !v6_r || out_ready;
  assign rd5 = !v5_r || rd6;
  assign rd4 = !v4_r || rd5;
  assign rd3 = !v3_r || rd4;
  assign rd2 = !v2_r || rd3;
  assign rd1 = !v1_r || rd2;
  assign in_ready  = rd1;
  assign out_valid = v6_r;

  // stage 1: basis products and hx*ht
  wide_t       pp1_r [4][4], pc1_r [4][4];
  wide_t       pp1_nxt [4][4], pc1_nxt [4][4];
  logic [63:0] hh1_r;
  // stage 2: interpolated fields, detJ
  word_t p2_r [4], q2_r [4], p2_nxt [4], q2_nxt [4];
  word_t dj2_r, dj2_nxt;
  // stage 3: field products
  word_t pp3_r [4], pq3_r [4], qq3_r [4];
  word_t dj3_r;
  // stage 4: potential derivatives
  word_t vpp4_r [4], vpc4_r [4], vcc4_r [4];
  word_t vpp4_nxt [4], vpc4_nxt [4], vcc4_nxt [4];
  word_t dj4_r;
  // stage 5: detJ scaled
  word_t cpp5_r [4], cpc5_r [4], tcc5_r [4];
  // stage 6: output terms, chi-row pair ghost scaled
  word_t c6_r [4][4];

  always_comb begin
    logic [63:0] dj;
    wide_t sp, sc;
    for (int g = 0; g < 4; g++) begin
      for (int n = 0; n < 4; n++) begin
        pp1_nxt[g][n] = wide_t'(BASIS_Q31[small_count(2'(n), g[1], g[0])]) * wide_t'(phi[n]);
        pc1_nxt[g][n] = wide_t'(BASIS_Q31[small_count(2'(n), g[1], g[0])]) * wide_t'(chi[n]);
      end
    end
    for (int g = 0; g < 4; g++) begin
      sp = pp1_r[g][0] + pp1_r[g][1] + pp1_r[g][2] + pp1_r[g][3];
      sc = pc1_r[g][0] + pc1_r[g][1] + pc1_r[g][2] + pc1_r[g][3];
      p2_nxt[g] = sat32(rnd_shr(sp, 31));
      q2_nxt[g] = sat32(rnd_shr(sc, 31));
    end
    dj = (hh1_r + (64'd1 << (FRAC_BITS + 1))) >> (FRAC_BITS + 2);
    dj2_nxt = (dj > 64'd2147483647) ? 32'sh7fffffff : word_t'(dj[31:0]);
    for (int g = 0; g < 4; g++) begin
      vpp4_nxt[g] = sat32(wide_t'(qmul(lam, qq3_r[g], FRAC_BITS)) <<< 1);
      vpc4_nxt[g] = sat32(wide_t'(qmul(lam, pq3_r[g], FRAC_BITS)) <<< 2);
      vcc4_nxt[g] = sat32(wide_t'(qmul(lam, pp3_r[g], FRAC_BITS)) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else begin
      if (rd1) v1_r <= in_valid;
      if (rd2) v2_r <= v1_r;
      if (rd3) v3_r <= v2_r;
      if (rd4) v4_r <= v3_r;
      if (rd5) v5_r <= v4_r;
      if (rd6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd1 && in_valid) begin
      pp1_r <= pp1_nxt;
      pc1_r <= pc1_nxt;
      hh1_r <= 64'(hx) * 64'(ht);
    end
    if (rd2 && v1_r) begin
      p2_r  <= p2_nxt;
      q2_r  <= q2_nxt;
      dj2_r <= dj2_nxt;
    end
    if (rd3 && v2_r) begin
      for (int g = 0; g < 4; g++) begin
        pp3_r[g] <= qmul(p2_r[g], p2_r[g], FRAC_BITS);
        pq3_r[g] <= qmul(p2_r[g], q2_r[g], FRAC_BITS);
        qq3_r[g] <= qmul(q2_r[g], q2_r[g], FRAC_BITS);
      end
      dj3_r <= dj2_r;
    end
    if (rd4 && v3_r) begin
      vpp4_r <= vpp4_nxt;
      vpc4_r <= vpc4_nxt;
      vcc4_r <= vcc4_nxt;
      dj4_r  <= dj3_r;
    end
    if (rd5 && v4_r) begin
      for (int g = 0; g < 4; g++) begin
        cpp5_r[g] <= qmul(vpp4_r[g], dj4_r, FRAC_BITS);
        cpc5_r[g] <= qmul(vpc4_r[g], dj4_r, FRAC_BITS);
        tcc5_r[g] <= qmul(vcc4_r[g], dj4_r, FRAC_BITS);
      end
    end
    if (rd6 && v5_r) begin
      for (int g = 0; g < 4; g++) begin
        c6_r[g][0] <= cpp5_r[g];
        c6_r[g][1] <= cpc5_r[g];
        c6_r[g][2] <= qmul(ghost, tcc5_r[g], FRAC_BITS);
        c6_r[g][3] <= qmul(ghost, cpc5_r[g], FRAC_BITS);
      end
    end
  end

  assign c_out = c6_r;

endmodule

// ----- rtl/cfej_asm.sv -----
// Assembly stage: holds one element's Gauss-point terms and emits 16 Jacobian items.
// Buffer, product stage and sum/round output register. Depends on cfej_pkg.
module cfej_asm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cfej_pkg::word_t  c_in [4][4],
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       row_node,
  output logic [1:0]       col_node,
  output cfej_pkg::word_t  j_out [4],
  output logic             last
);
  import cfej_pkg::*;

  word_t      c_r [4][4];
  logic       bv_r;
  logic [3:0] cnt_r;
  logic       o1v_r, o2v_r;
  logic       o1rdy, o2rdy, emit, load;
  wide_t      pr1_r [4][4], pr1_nxt [4][4];
  logic [3:0] k1_r, k2_r;
  word_t      j2_r [4], j2_nxt [4];

  assign o2rdy    = !o2v_r || out_ready;
  assign o1rdy    = !o1v_r || o2rdy;
  assign emit     = bv_r && o1rdy;
  assign in_ready = !bv_r || (emit && cnt_r == 4'd15);
  assign load     = in_valid && in_ready;

  always_comb begin
    wide_t acc;
    for (int g = 0; g < 4; g++) begin
      for (int m = 0; m < 4; m++) begin
        pr1_nxt[g][m] = wide_t'(PAIR_Q31[3'(small_count(cnt_r[3:2], g[1], g[0]))
                                       + 3'(small_count(cnt_r[1:0], g[1], g[0]))])
                        * wide_t'(c_r[g][m]);
      end
    end
    for (int m = 0; m < 4; m++) begin
      acc = pr1_r[0][m] + pr1_r[1][m] + pr1_r[2][m] + pr1_r[3][m];
      j2_nxt[m] = sat32(rnd_shr(acc, 31));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r  <= 1'b0;
      cnt_r <= 4'd0;
      o1v_r <= 1'b0;
      o2v_r <= 1'b0;
    end else begin
      if (emit) cnt_r <= cnt_r + 4'd1;
      if (load) bv_r <= 1'b1;
      else if (emit && cnt_r == 4'd15) bv_r <= 1'b0;
      if (o1rdy) o1v_r <= emit;
      if (o2rdy) o2v_r <= o1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) c_r <= c_in;
    if (emit) begin
      pr1_r <= pr1_nxt;
      k1_r  <= cnt_r;
    end
    if (o2rdy && o1v_r) begin
      j2_r <= j2_nxt;
      k2_r <= k1_r;
    end
  end

  assign out_valid = o2v_r;
  assign row_node  = k2_r[3:2];
  assign col_node  = k2_r[1:0];
  assign j_out     = j2_r;
  assign last      = k2_r == 4'd15;

`ifndef SYNTH
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n) !bv_r |-> cnt_r == 4'd0)
    else $error("count not parked while buffer empty");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bv_r && cnt_r != 4'd15 |-> !in_ready)
    else $error("buffer overwritten mid element");
  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    o1v_r && !o1rdy |=> o1v_r)
    else $error("product stage lost an item");
`endif

endmodule

// ----- rtl/coupled_field_element_jacobian_core.sv -----
// Top level of the coupled-field element Jacobian core: ports, config registers, packing.
// Depends on cfej_pkg, cfej_front and cfej_asm.
//
// Usage: one input item carries the nodal values of phi and chi on a bilinear
// space-time element plus its width and duration (in_* stream). The core
// returns 16 items on the out_* stream, row node outer, column node inner,
// each carrying the four block entries; out_tlast marks the sixteenth.
// cfg_we/cfg_index/cfg_data write coupling_gain (0) and ghost_scale (1); write
// only while no element is in flight.
// Path to the first result: six Gauss-point stages, assembly buffer, product
// stage, output register. The single assembly product stage produces one result
// item per cycle unless out_tready stalls it; the next element enters the
// six-stage Gauss-point pipeline while the current one drains.
// Reset (synchronous, rst_n low): pipeline empties, both registers return to
// 1.0. A stalled out_tready holds the output register and backs up the
// pipeline stage by stage; nothing is dropped or repeated.
module coupled_field_element_jacobian_core #(
  parameter int unsigned FRAC_BITS = cfej_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // phi_node0..3, chi_node0..3, elem_width, elem_duration (32 bits each)
  input  logic [cfej_pkg::TDATA_IN_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // row_node, col_node, j_phiphi, j_phichi, j_chichi, j_chiphi, 4 zero bits
  output logic [cfej_pkg::TDATA_OUT_W-1:0]   out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [31:0]                        cfg_data
);
  import cfej_pkg::*;

  localparam word_t ONE = word_t'(64'sd1 <<< FRAC_BITS);

  word_t gain_r, ghost_r;
  word_t phi [4], chi [4];
  word_t c_mid [4][4];
  word_t j_out [4];
  logic  mid_valid, mid_ready;
  logic [1:0] row_node, col_node;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= ONE;
      ghost_r <= ONE;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COUPLING_GAIN: gain_r  <= cfg_data;
        REG_GHOST_SCALE:   ghost_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      phi[n] = in_tdata[32*n +: 32];
      chi[n] = in_tdata[128 + 32*n +: 32];
    end
  end

  cfej_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .phi, .chi,
    .hx(in_tdata[287:256]), .ht(in_tdata[319:288]),
    .lam(gain_r), .ghost(ghost_r),
    .out_valid(mid_valid), .out_ready(mid_ready),
    .c_out(c_mid)
  );

  cfej_asm u_asm (
    .clk, .rst_n,
    .in_valid(mid_valid), .in_ready(mid_ready),
    .c_in(c_mid),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .row_node, .col_node, .j_out,
    .last(out_tlast)
  );

  assign out_tdata = {4'd0, j_out[3], j_out[2], j_out[1], j_out[0], col_node, row_node};

`ifndef SYNTH
  a_last_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == 4'hf)
    else $error("tlast on wrong node pair");
  a_cfg_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) && !$past(cfg_we) |-> gain_r == ONE && ghost_r == ONE)
    else $error("config registers not at reset value");
  a_ready_after_reset: assert property (@(posedge clk) rst_n && $past(!rst_n) |-> in_tready)
    else $error("input not ready after reset");
`endif

endmodule
